/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the weighted log-likelihood accumulator.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// expr must never be true at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

/* hdl/wlla_pkg.sv */
// Shared constants, codes and control structs of the weighted log-likelihood accumulator.
// No dependencies; used by wlla_mul, wlla_ctrl and the top level.
`timescale 1ns / 1ps

package wlla_pkg;

   // input / register field widths
   localparam int PROB_FRAC_BITS = 24;
   localparam int PROB_W         = 25;
   localparam int CLASS_W        = 2;
   localparam int GAIN_W         = 24;
   localparam int GAIN_FRAC_BITS = 20;
   localparam int CSR_IDX_W      = 1;

   // allele class codes
   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_ONE  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_TWO  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ONE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_TWO = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << GAIN_FRAC_BITS);

   // marker sum
   localparam int SUM_W  = 48;
   localparam int TERM_W = PROB_W + GAIN_W - GAIN_FRAC_BITS;

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [1:0] MUL_OP_TERM   = 2'd0;
   localparam logic [1:0] MUL_OP_SQUARE = 2'd1;
   localparam logic [1:0] MUL_OP_LN2    = 2'd2;

   // log unit
   localparam int MANT_W         = 32;
   localparam int EXP_W          = $clog2(SUM_W);
   localparam int EXPD_W         = EXP_W + 1;
   localparam int LOG2_FRAC_BITS = 20;
   localparam int L2_W           = EXPD_W + LOG2_FRAC_BITS;
   localparam int NORM_STEPS     = EXP_W;
   localparam int NORM_IDX_W     = $clog2(NORM_STEPS);
   localparam int SQ_STEPS       = LOG2_FRAC_BITS;
   localparam int SQ_CNT_W       = $clog2(SQ_STEPS);
   localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
   localparam int RND_SHIFT      = LOG2_FRAC_BITS + 32 - 16;
   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SHIFT - 1);
   localparam int LN_W           = L2_W + 32 - RND_SHIFT + 1;

   // row total, signed Q16.16
   localparam int ROW_W = 32;
   localparam logic [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
   localparam logic [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

   typedef struct packed {
      logic end_marker;
      logic end_row;
      logic sum_zero;
      logic rsp_free;
   } status_type;

   typedef struct packed {
      logic                  load_item;
      logic                  mul_en;
      logic [1:0]            mul_op;
      logic                  accum;
      logic                  norm_step;
      logic [NORM_IDX_W-1:0] norm_index;
      logic                  sq_update;
      logic                  ln_round;
      logic                  row_add;
      logic                  emit;
   } ctrl_type;

endpackage

/* hdl/weighted_log_likelihood_accumulator.sv */
// Top level of the weighted log-likelihood accumulator: datapath registers, log unit,
// row total and result register. Depends on wlla_pkg, wlla_mul, wlla_ctrl, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Weighted log-likelihood accumulator. Each req beat carries one Q1.24 probability
// (tdata), its risk-allele class (tuser[1:0]), a marker-end mark (tuser[2]) and a
// row-end mark (tlast). Class 0 adds the probability as is to the marker sum, class 1
// and 2 weight it by the Q4.20 gains in CSR 0 and 1, class 3 adds nothing. A marker
// end adds ln(marker sum) in Q16.16 to a saturating row total (a zero sum adds -2^31
// and sets the zero flag); a row end sends one rsp beat and clears the row. Items are
// handled one at a time: req_tready is high only while the sequencer idles. A plain
// item steps through accept, multiply and accumulate; a row end with no marker end
// adds an emit that waits on a still-unread result; a zero-sum marker end adds a row
// add; a marker end with a nonzero sum adds 6 normalize steps, 20 square-and-update
// passes through the one shared 32x32 multiplier, ln2 scale, round and row add, plus
// an emit for a row end. A finished result waits in the rsp register while the next
// items are taken.
module weighted_log_likelihood_accumulator (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [24:0] probability, rest zero
   input  logic [2:0]  req_tuser,   // [1:0] allele_class, [2] last_of_marker
   input  logic        req_tlast,   // last_of_row

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] log_total
   output logic [1:0]  rsp_tuser,   // [0] zero_sum_seen, [1] saturated

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wlla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wlla_pkg::GAIN_W-1:0]      csr_data
);

   localparam int SUM_W  = wlla_pkg::SUM_W;
   localparam int MANT_W = wlla_pkg::MANT_W;
   localparam int ROW_W  = wlla_pkg::ROW_W;
   localparam int LN_W   = wlla_pkg::LN_W;

   wlla_pkg::ctrl_type   ctrl;
   wlla_pkg::status_type status;

   logic req_fire;

   // config
   logic [wlla_pkg::GAIN_W-1:0] gain_one_ff, gain_two_ff;

   // current item
   logic [wlla_pkg::PROB_W-1:0]  prob_ff;
   logic [wlla_pkg::CLASS_W-1:0] class_ff;
   logic                         end_marker_ff, end_row_ff;

   // architectural state
   logic [SUM_W-1:0] marker_sum_ff, marker_sum_in;
   logic [ROW_W-1:0] row_total_ff, row_total_in;
   logic             zero_flag_ff, zero_flag_in;
   logic             sat_flag_ff, sat_flag_in;

   // log unit
   logic [SUM_W-1:0]                   norm_ff, norm_in;
   logic [wlla_pkg::EXP_W-1:0]         e_ff, e_in;
   logic [wlla_pkg::LOG2_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [LN_W-1:0]                    ln_ff, ln_in;

   // result register
   logic             rsp_valid_ff;
   logic [ROW_W-1:0] rsp_data_ff;
   logic             rsp_zero_ff, rsp_sat_ff;

   // multiplier
   logic [wlla_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [wlla_pkg::PROD_W-1:0] product;
   logic [wlla_pkg::GAIN_W-1:0] gain_sel;

   // datapath intermediates
   logic [wlla_pkg::TERM_W-1:0] term;
   logic [SUM_W:0]              sum_wide;
   logic [SUM_W-1:0]            sum_next;
   logic [wlla_pkg::EXPD_W-1:0] exp_diff;
   logic [wlla_pkg::L2_W-1:0]   l2, l2_mag;
   logic                        l2_neg;
   logic [MANT_W:0]             sq_top;
   logic [wlla_pkg::PROD_W-1:0] rnd_sum;
   logic [LN_W-2:0]             rnd_mag;
   logic                        sum_is_zero;
   logic [ROW_W:0]              add_val, row_sum;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign status.end_marker = end_marker_ff;
   assign status.end_row    = end_row_ff;
   assign status.sum_zero   = (sum_next == '0);
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   wlla_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire),
      .status (status),
      .ready  (req_tready),
      .ctrl   (ctrl)
   );

   wlla_mul u_mul (
      .clock   (clock),
      .mul_en  (ctrl.mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // gain per class; class 0 runs through the multiplier at unity
   always_comb begin
      unique case (class_ff)
         wlla_pkg::CLASS_NONE: gain_sel = wlla_pkg::GAIN_UNITY;
         wlla_pkg::CLASS_ONE:  gain_sel = gain_one_ff;
         wlla_pkg::CLASS_TWO:  gain_sel = gain_two_ff;
         default:              gain_sel = '0;
      endcase
   end

   // log2 = (e - frac bits).frac, sign/magnitude for the ln2 multiply
   assign exp_diff = {1'b0, e_ff} - wlla_pkg::EXPD_W'(wlla_pkg::PROB_FRAC_BITS);
   assign l2       = {exp_diff, frac_ff};
   assign l2_neg   = exp_diff[wlla_pkg::EXPD_W-1];
   assign l2_mag   = l2_neg ? (-l2) : l2;

   always_comb begin
      unique case (ctrl.mul_op)
         wlla_pkg::MUL_OP_TERM: begin
            mul_a = wlla_pkg::MUL_W'(prob_ff);
            mul_b = wlla_pkg::MUL_W'(gain_sel);
         end
         wlla_pkg::MUL_OP_SQUARE: begin
            mul_a = norm_ff[SUM_W-1 -: MANT_W];
            mul_b = norm_ff[SUM_W-1 -: MANT_W];
         end
         wlla_pkg::MUL_OP_LN2: begin
            mul_a = wlla_pkg::MUL_W'(l2_mag);
            mul_b = wlla_pkg::LN2_Q32;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // saturating marker accumulate
   assign term     = product[wlla_pkg::GAIN_FRAC_BITS +: wlla_pkg::TERM_W];
   assign sum_wide = {1'b0, marker_sum_ff} + (SUM_W+1)'(term);
   assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   // squaring: Q1.31 * Q1.31 >> 31, renormalize on overflow past 2.0
   assign sq_top  = product[MANT_W-1 +: MANT_W+1];

   // round to Q16.16, ties away from zero on the magnitude
   assign rnd_sum = product + wlla_pkg::RND_HALF;
   assign rnd_mag = rnd_sum[wlla_pkg::RND_SHIFT +: LN_W-1];

   // row update, a zero marker sum adds the most negative value
   assign sum_is_zero = (marker_sum_ff == '0);
   assign add_val = sum_is_zero ? {wlla_pkg::ROW_MIN[ROW_W-1], wlla_pkg::ROW_MIN}
                                : {{(ROW_W+1-LN_W){ln_ff[LN_W-1]}}, ln_ff};
   assign row_sum = {row_total_ff[ROW_W-1], row_total_ff} + add_val;

   always_comb begin
      marker_sum_in = marker_sum_ff;
      row_total_in  = row_total_ff;
      zero_flag_in  = zero_flag_ff;
      sat_flag_in   = sat_flag_ff;
      norm_in       = norm_ff;
      e_in          = e_ff;
      frac_in       = frac_ff;
      ln_in         = ln_ff;

      if (ctrl.accum) begin
         marker_sum_in = sum_next;
         norm_in       = sum_next;
         e_in          = wlla_pkg::EXP_W'(SUM_W - 1);
      end

      // binary search for the top set bit: shifts of 32, 16, 8, 4, 2, 1
      if (ctrl.norm_step) begin
         unique case (ctrl.norm_index)
            3'd0: if (norm_ff[SUM_W-1 -: 32] == '0) begin
               norm_in = norm_ff << 32;
               e_in    = e_ff - 6'd32;
            end
            3'd1: if (norm_ff[SUM_W-1 -: 16] == '0) begin
               norm_in = norm_ff << 16;
               e_in    = e_ff - 6'd16;
            end
            3'd2: if (norm_ff[SUM_W-1 -: 8] == '0) begin
               norm_in = norm_ff << 8;
               e_in    = e_ff - 6'd8;
            end
            3'd3: if (norm_ff[SUM_W-1 -: 4] == '0) begin
               norm_in = norm_ff << 4;
               e_in    = e_ff - 6'd4;
            end
            3'd4: if (norm_ff[SUM_W-1 -: 2] == '0) begin
               norm_in = norm_ff << 2;
               e_in    = e_ff - 6'd2;
            end
            3'd5: if (!norm_ff[SUM_W-1]) begin
               norm_in = norm_ff << 1;
               e_in    = e_ff - 6'd1;
            end
            default: begin
               norm_in = norm_ff;
            end
         endcase
      end

      if (ctrl.sq_update) begin
         norm_in[SUM_W-1 -: MANT_W] = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
         frac_in = {frac_ff[wlla_pkg::LOG2_FRAC_BITS-2:0], sq_top[MANT_W]};
      end

      if (ctrl.ln_round) begin
         ln_in = l2_neg ? (-{1'b0, rnd_mag}) : {1'b0, rnd_mag};
      end

      if (ctrl.row_add) begin
         marker_sum_in = '0;
         zero_flag_in  = zero_flag_ff || sum_is_zero;
         if (row_sum[ROW_W] != row_sum[ROW_W-1]) begin
            row_total_in = row_sum[ROW_W] ? wlla_pkg::ROW_MIN : wlla_pkg::ROW_MAX;
            sat_flag_in  = 1'b1;
         end else begin
            row_total_in = row_sum[ROW_W-1:0];
         end
      end

      if (ctrl.emit) begin
         row_total_in = '0;
         zero_flag_in = 1'b0;
         sat_flag_in  = 1'b0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_one_ff   <= wlla_pkg::GAIN_UNITY;
         gain_two_ff   <= wlla_pkg::GAIN_UNITY;
         marker_sum_ff <= '0;
         row_total_ff  <= '0;
         zero_flag_ff  <= 1'b0;
         sat_flag_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               wlla_pkg::CSR_GAIN_ONE: gain_one_ff <= csr_data;
               wlla_pkg::CSR_GAIN_TWO: gain_two_ff <= csr_data;
               default: gain_one_ff <= gain_one_ff;
            endcase
         end
         marker_sum_ff <= marker_sum_in;
         row_total_ff  <= row_total_in;
         zero_flag_ff  <= zero_flag_in;
         sat_flag_ff   <= sat_flag_in;
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         prob_ff       <= req_tdata[wlla_pkg::PROB_W-1:0];
         class_ff      <= req_tuser[wlla_pkg::CLASS_W-1:0];
         end_marker_ff <= req_tuser[wlla_pkg::CLASS_W];
         end_row_ff    <= req_tlast;
      end
      norm_ff <= norm_in;
      e_ff    <= e_in;
      frac_ff <= frac_in;
      ln_ff   <= ln_in;
      if (ctrl.emit) begin
         rsp_data_ff <= row_total_ff;
         rsp_zero_ff <= zero_flag_ff;
         rsp_sat_ff  <= sat_flag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_zero_ff};

   `ASSERT_CLK(a_mant_normalized, clock, reset, (ctrl.mul_en && ctrl.mul_op == wlla_pkg::MUL_OP_SQUARE) |-> norm_ff[SUM_W-1], "squaring operand lost its leading one")
   `ASSERT_CLK(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(ctrl.emit), "rsp valid rose without an emit")
   `ASSERT_CLK(a_sat_clipped, clock, reset, $rose(sat_flag_ff) |-> (row_total_ff == wlla_pkg::ROW_MAX || row_total_ff == wlla_pkg::ROW_MIN), "saturation flag set off a limit")
   `ASSERT_NEVER(a_ready_while_busy, clock, reset, req_tready && (ctrl.accum || ctrl.row_add || ctrl.mul_en), "input ready during item processing")

endmodule

/* hdl/wlla_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
// Depends on wlla_pkg for widths.
`timescale 1ns / 1ps

module wlla_mul (
   input  logic                         clock,
   input  logic                         mul_en,
   input  logic [wlla_pkg::MUL_W-1:0]   mul_a,
   input  logic [wlla_pkg::MUL_W-1:0]   mul_b,
   output logic [wlla_pkg::PROD_W-1:0]  product
);

   logic [wlla_pkg::PROD_W-1:0] product_ff;
   logic [wlla_pkg::PROD_W-1:0] product_in;

   assign product_in = wlla_pkg::PROD_W'(mul_a) * wlla_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* hdl/wlla_ctrl.sv */
// Sequencer of the accumulator: steps one item through term, normalize, squaring,
// ln2 scaling, row update and emit. Depends on wlla_pkg for codes and structs.
`timescale 1ns / 1ps

module wlla_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  wlla_pkg::status_type status,
   output logic                 ready,
   output wlla_pkg::ctrl_type   ctrl
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TERM    = 4'd1;
   localparam logic [3:0] S_ACCUM   = 4'd2;
   localparam logic [3:0] S_NORM    = 4'd3;
   localparam logic [3:0] S_SQ_MUL  = 4'd4;
   localparam logic [3:0] S_SQ_UPD  = 4'd5;
   localparam logic [3:0] S_LN_MUL  = 4'd6;
   localparam logic [3:0] S_LN_RND  = 4'd7;
   localparam logic [3:0] S_ROW_ADD = 4'd8;
   localparam logic [3:0] S_EMIT    = 4'd9;

   logic [3:0]                      state_ff, state_in;
   logic [wlla_pkg::NORM_IDX_W-1:0] idx_ff, idx_in;
   logic [wlla_pkg::SQ_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      ctrl     = '0;
      ctrl.norm_index = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load_item = 1'b1;
               state_in       = S_TERM;
            end
         end
         S_TERM: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = wlla_pkg::MUL_OP_TERM;
            state_in    = S_ACCUM;
         end
         S_ACCUM: begin
            ctrl.accum = 1'b1;
            idx_in     = '0;
            priority if (status.end_marker && status.sum_zero) begin
               state_in = S_ROW_ADD;
            end else if (status.end_marker) begin
               state_in = S_NORM;
            end else if (status.end_row) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_NORM: begin
            ctrl.norm_step = 1'b1;
            if (idx_ff == wlla_pkg::NORM_IDX_W'(wlla_pkg::NORM_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_SQ_MUL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SQ_MUL: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = wlla_pkg::MUL_OP_SQUARE;
            state_in    = S_SQ_UPD;
         end
         S_SQ_UPD: begin
            ctrl.sq_update = 1'b1;
            if (cnt_ff == wlla_pkg::SQ_CNT_W'(wlla_pkg::SQ_STEPS - 1)) begin
               state_in = S_LN_MUL;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SQ_MUL;
            end
         end
         S_LN_MUL: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = wlla_pkg::MUL_OP_LN2;
            state_in    = S_LN_RND;
         end
         S_LN_RND: begin
            ctrl.ln_round = 1'b1;
            state_in      = S_ROW_ADD;
         end
         S_ROW_ADD: begin
            ctrl.row_add = 1'b1;
            state_in     = status.end_row ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               ctrl.emit = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign ready = (state_ff == S_IDLE);

endmodule
